// ===== hw/rtl/c8cpu_pkg.sv =====
// ----------------------------------------------------------------------------
// c8cpu_pkg
// Shared types and constants of the CHIP-8 core: sizes, the sequencer step
// encoding, controller/datapath command and status, and the font table.
// ----------------------------------------------------------------------------
package c8cpu_pkg;

    // machine sizes
    localparam int MEMORY_BYTES  = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int NUM_REGS      = 16;

    localparam int MEM_AW = $clog2(MEMORY_BYTES);
    localparam int ROW_AW = $clog2(SCREEN_HEIGHT);
    localparam int REG_AW = $clog2(NUM_REGS);
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = MEM_AW;

    localparam logic [11:0] PC_RESET   = 12'h200;
    localparam int          FONT_BYTES = 80;

    // host command codes
    typedef enum logic [1:0] {
        HC_EXEC  = 2'd0,
        HC_WRITE = 2'd1,
        HC_READ  = 2'd2,
        HC_ROW   = 2'd3
    } t_host_cmd;

    // sequencer steps, one-hot
    localparam int STEP_W = 25;
    typedef enum logic [STEP_W-1:0] {
        ST_CLEAR = STEP_W'(1) << 0,
        ST_IDLE  = STEP_W'(1) << 1,
        ST_DISP  = STEP_W'(1) << 2,
        ST_HWR   = STEP_W'(1) << 3,
        ST_HRD   = STEP_W'(1) << 4,
        ST_HROW  = STEP_W'(1) << 5,
        ST_HCAP  = STEP_W'(1) << 6,
        ST_F1    = STEP_W'(1) << 7,
        ST_F2    = STEP_W'(1) << 8,
        ST_F3    = STEP_W'(1) << 9,
        ST_F4    = STEP_W'(1) << 10,
        ST_F5    = STEP_W'(1) << 11,
        ST_F6    = STEP_W'(1) << 12,
        ST_EXEC  = STEP_W'(1) << 13,
        ST_WRF   = STEP_W'(1) << 14,
        ST_CLS   = STEP_W'(1) << 15,
        ST_SPRA  = STEP_W'(1) << 16,
        ST_SPRB  = STEP_W'(1) << 17,
        ST_BCD   = STEP_W'(1) << 18,
        ST_STA   = STEP_W'(1) << 19,
        ST_STB   = STEP_W'(1) << 20,
        ST_LDA   = STEP_W'(1) << 21,
        ST_LDB   = STEP_W'(1) << 22,
        ST_FIN   = STEP_W'(1) << 23,
        ST_DONE  = STEP_W'(1) << 24
    } t_step;

    // what the decoded instruction needs after its first execute cycle
    typedef enum logic [2:0] {
        OC_FIN   = 3'd0,
        OC_FLAG  = 3'd1,
        OC_CLS   = 3'd2,
        OC_DRAW  = 3'd3,
        OC_DRAW0 = 3'd4,
        OC_BCD   = 3'd5,
        OC_STORE = 3'd6,
        OC_LOAD  = 3'd7
    } t_opclass;

    // controller to datapath
    typedef struct packed {
        t_step            step;
        logic [CNT_W-1:0] cnt;
        logic             take;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        t_host_cmd   hcmd;
        t_opclass    cls;
        logic [3:0]  lim;
        logic        out_free;
    } t_stat;

    // hex digit glyphs
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

// ===== hw/rtl/c8cpu_if.sv =====
// ----------------------------------------------------------------------------
// c8cpu_if
// Request and response channels of the CHIP-8 core, valid/ready handshake.
// ----------------------------------------------------------------------------
interface c8cpu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] keys_down;
    logic [3:0]  waited_key;
    logic [7:0]  random_byte;

    modport source (output valid, cmd, address, data_byte, keys_down, waited_key,
                    random_byte, input ready);
    modport sink   (input valid, cmd, address, data_byte, keys_down, waited_key,
                    random_byte, output ready);
endinterface

interface c8cpu_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [7:0]  read_byte;
    logic [63:0] screen_row;
    logic        drew;
    logic        beep;

    modport source (output valid, program_counter, read_byte, screen_row, drew, beep,
                    input ready);
    modport sink   (input valid, program_counter, read_byte, screen_row, drew, beep,
                    output ready);
endinterface

// ===== hw/rtl/c8cpu_ram.sv =====
// ----------------------------------------------------------------------------
// c8cpu_ram
// Generic single-port RAM, one address for write and read, registered read.
// ----------------------------------------------------------------------------
module c8cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/c8cpu_ctrl.sv =====
// ----------------------------------------------------------------------------
// c8cpu_ctrl
// Sequencer of the CHIP-8 core: reset sweep, host commands, fetch, decode,
// multi-cycle instruction loops, timer tick and result handoff.
// ----------------------------------------------------------------------------
module c8cpu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  c8cpu_pkg::t_stat i_stat,
    output c8cpu_pkg::t_ctl  o_ctl
);
    import c8cpu_pkg::*;

    t_step            r_step, n_step;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             take;

    assign take       = (r_step == ST_IDLE) && i_in_valid;
    assign o_in_ready = (r_step == ST_IDLE);

    // next step and loop counter
    always_comb begin
        n_step = r_step;
        n_cnt  = r_cnt;
        case (r_step)
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MEMORY_BYTES - 1)) begin
                    n_step = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take) begin
                    n_step = ST_DISP;
                end
            end
            ST_DISP: begin
                case (i_stat.hcmd)
                    HC_EXEC:  n_step = ST_F1;
                    HC_WRITE: n_step = ST_HWR;
                    HC_READ:  n_step = ST_HRD;
                    default:  n_step = ST_HROW;
                endcase
            end
            ST_HWR:  n_step = ST_DONE;
            ST_HRD:  n_step = ST_HCAP;
            ST_HROW: n_step = ST_HCAP;
            ST_HCAP: n_step = ST_DONE;
            ST_F1:   n_step = ST_F2;
            ST_F2:   n_step = ST_F3;
            ST_F3:   n_step = ST_F4;
            ST_F4:   n_step = ST_F5;
            ST_F5:   n_step = ST_F6;
            ST_F6:   n_step = ST_EXEC;
            ST_EXEC: begin
                n_cnt = '0;
                case (i_stat.cls)
                    OC_FLAG:  n_step = ST_WRF;
                    OC_CLS:   n_step = ST_CLS;
                    OC_DRAW:  n_step = ST_SPRA;
                    OC_DRAW0: n_step = ST_WRF;
                    OC_BCD:   n_step = ST_BCD;
                    OC_STORE: n_step = ST_STA;
                    OC_LOAD:  n_step = ST_LDA;
                    default:  n_step = ST_FIN;
                endcase
            end
            ST_WRF: n_step = ST_FIN;
            ST_CLS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCREEN_HEIGHT - 1)) begin
                    n_step = ST_FIN;
                end
            end
            ST_SPRA: n_step = ST_SPRB;
            ST_SPRB: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == 4'(i_stat.lim - 4'd1)) begin
                    n_step = ST_WRF;
                end else begin
                    n_step = ST_SPRA;
                end
            end
            ST_BCD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_step = ST_FIN;
                end
            end
            ST_STA: n_step = ST_STB;
            ST_STB: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == i_stat.lim) begin
                    n_step = ST_FIN;
                end else begin
                    n_step = ST_STA;
                end
            end
            ST_LDA: n_step = ST_LDB;
            ST_LDB: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == i_stat.lim) begin
                    n_step = ST_FIN;
                end else begin
                    n_step = ST_LDA;
                end
            end
            ST_FIN: n_step = ST_DONE;
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_step = ST_IDLE;
                end
            end
            default: n_step = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
            r_cnt  <= '0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
    end

    assign o_ctl.step = r_step;
    assign o_ctl.cnt  = r_cnt;
    assign o_ctl.take = take;
endmodule

// ===== hw/rtl/c8cpu_dp.sv =====
// ----------------------------------------------------------------------------
// c8cpu_dp
// Datapath of the CHIP-8 core: memory, register file and screen RAMs,
// PC, index, stack, timers, instruction decode and the result register.
// ----------------------------------------------------------------------------
module c8cpu_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c8cpu_pkg::t_ctl  i_ctl,
    output c8cpu_pkg::t_stat o_stat,
    input  logic [1:0]       i_cmd,
    input  logic [11:0]      i_address,
    input  logic [7:0]       i_data_byte,
    input  logic [15:0]      i_keys_down,
    input  logic [3:0]       i_waited_key,
    input  logic [7:0]       i_random_byte,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [11:0]      o_program_counter,
    output logic [7:0]       o_read_byte,
    output logic [63:0]      o_screen_row,
    output logic             o_drew,
    output logic             o_beep
);
    import c8cpu_pkg::*;

    // opcode groups and sub-opcodes
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SE_K  = 4'h3;
    localparam logic [3:0] OP_SNE_K = 4'h4;
    localparam logic [3:0] OP_SE_R  = 4'h5;
    localparam logic [3:0] OP_LD_K  = 4'h6;
    localparam logic [3:0] OP_ADD_K = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNE_R = 4'h9;
    localparam logic [3:0] OP_LD_I  = 4'hA;
    localparam logic [3:0] OP_JP_V0 = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_SKP   = 4'hE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] SYS_CLS     = 8'hE0;
    localparam logic [7:0] SYS_RET     = 8'hEE;
    localparam logic [7:0] KEY_DOWN    = 8'h9E;
    localparam logic [7:0] KEY_UP      = 8'hA1;
    localparam logic [7:0] MISC_GET_DT = 8'h07;
    localparam logic [7:0] MISC_WAIT   = 8'h0A;
    localparam logic [7:0] MISC_SET_DT = 8'h15;
    localparam logic [7:0] MISC_SET_ST = 8'h18;
    localparam logic [7:0] MISC_ADD_I  = 8'h1E;
    localparam logic [7:0] MISC_FONT   = 8'h29;
    localparam logic [7:0] MISC_BCD    = 8'h33;
    localparam logic [7:0] MISC_STORE  = 8'h55;
    localparam logic [7:0] MISC_LOAD   = 8'h65;

    localparam logic [REG_AW-1:0] FLAG_REG = REG_AW'(NUM_REGS - 1);
    localparam logic [SP_W-1:0]   SP_MAX   = SP_W'(STACK_DEPTH - 1);

    // decimal digit of an 8-bit value: hundreds, tens, ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = 7'(v - 8'(h) * 8'd100);
        prod = 15'(rem) * 15'd205;
        t    = 4'(prod >> 11);
        o    = 4'(rem - 7'(t) * 7'd10);
        case (sel)
            2'd0:    bcd_digit = {6'b0, h};
            2'd1:    bcd_digit = {4'b0, t};
            default: bcd_digit = {4'b0, o};
        endcase
    endfunction

    // architectural state
    logic [11:0]     r_pc;
    logic [15:0]     r_idx;
    logic [SP_W-1:0] r_sp;
    logic [7:0]      r_dt;
    logic [7:0]      r_st;
    logic [11:0]     r_stack [STACK_DEPTH];

    // per-transaction holding registers
    t_host_cmd   r_hcmd;
    logic [11:0] r_haddr;
    logic [7:0]  r_hdata;
    logic [15:0] r_keys;
    logic [3:0]  r_waited;
    logic [7:0]  r_rnd;
    logic [7:0]  r_ophi, r_oplo, r_vx, r_vy, r_v0;
    logic        r_flag, r_drew, r_beep;
    logic [7:0]  r_rd;
    logic [63:0] r_row;

    // result register
    logic        r_out_valid;
    logic [11:0] r_opc;
    logic [7:0]  r_ord;
    logic [63:0] r_orow;
    logic        r_odrew, r_obeep;

    // ram ports
    logic              mem_we, reg_we, frm_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [REG_AW-1:0] reg_addr;
    logic [ROW_AW-1:0] frm_addr;
    logic [7:0]        mem_wd, mem_rd, reg_wd, reg_rd;
    logic [63:0]       frm_wd, frm_rd;

    // decode fields
    logic [3:0]  op_nib, op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn, pc2, pc4;
    logic [SP_W-1:0] sp_inc, sp_dec;

    // execute results
    logic [11:0] e_pc;
    logic        e_wx_en, e_flag, e_push, e_pop, e_idx_en, e_dt_en, e_st_en, e_drew;
    logic [7:0]  e_wx;
    logic [15:0] e_idx;
    t_opclass    e_cls;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic        key_down;

    logic [127:0] spr_wide;
    logic [63:0]  spr_mask;
    logic         loop_last, load_out;

    assign op_nib = r_ophi[7:4];
    assign op_x   = r_ophi[3:0];
    assign op_y   = r_oplo[7:4];
    assign op_n   = r_oplo[3:0];
    assign op_kk  = r_oplo;
    assign op_nnn = {r_ophi[3:0], r_oplo};
    assign pc2    = r_pc + 12'd2;
    assign pc4    = r_pc + 12'd4;
    assign sp_inc = (r_sp == SP_MAX) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? SP_MAX : r_sp - 1'b1;
    assign key_down = r_keys[r_vx[3:0]];

    // sprite byte placed on the row with horizontal wrap
    assign spr_wide = {mem_rd, 56'b0, mem_rd, 56'b0} >> r_vx[5:0];
    assign spr_mask = spr_wide[63:0];

    assign loop_last = (i_ctl.cnt[3:0] == op_x);
    assign load_out  = (i_ctl.step == ST_DONE) && (!r_out_valid || i_out_ready);

    // instruction decode and execute
    always_comb begin
        e_pc     = r_pc;
        e_wx_en  = 1'b0;
        e_wx     = r_vx;
        e_flag   = 1'b0;
        e_cls    = OC_FIN;
        e_push   = 1'b0;
        e_pop    = 1'b0;
        e_idx_en = 1'b0;
        e_idx    = r_idx;
        e_dt_en  = 1'b0;
        e_st_en  = 1'b0;
        e_drew   = 1'b0;
        sum9     = {1'b0, r_vx} + {1'b0, r_vy};
        sum17    = {1'b0, r_idx} + {9'b0, r_vx};
        case (op_nib)
            OP_SYS: begin
                if (op_kk == SYS_CLS) begin
                    e_cls  = OC_CLS;
                    e_drew = 1'b1;
                    e_pc   = pc2;
                end else if (op_kk == SYS_RET) begin
                    e_pop = 1'b1;
                    e_pc  = r_stack[sp_dec] + 12'd2;
                end
            end
            OP_JP: e_pc = op_nnn;
            OP_CALL: begin
                e_push = 1'b1;
                e_pc   = op_nnn;
            end
            OP_SE_K:  e_pc = (r_vx == op_kk) ? pc4 : pc2;
            OP_SNE_K: e_pc = (r_vx != op_kk) ? pc4 : pc2;
            OP_SE_R:  e_pc = (r_vx == r_vy) ? pc4 : pc2;
            OP_SNE_R: e_pc = (r_vx != r_vy) ? pc4 : pc2;
            OP_LD_K: begin
                e_wx_en = 1'b1;
                e_wx    = op_kk;
                e_pc    = pc2;
            end
            OP_ADD_K: begin
                e_wx_en = 1'b1;
                e_wx    = r_vx + op_kk;
                e_pc    = pc2;
            end
            OP_ALU: begin
                e_pc    = pc2;
                e_wx_en = 1'b1;
                case (op_n)
                    ALU_MOV: e_wx = r_vy;
                    ALU_OR:  e_wx = r_vx | r_vy;
                    ALU_AND: e_wx = r_vx & r_vy;
                    ALU_XOR: e_wx = r_vx ^ r_vy;
                    ALU_ADD: begin
                        e_wx   = sum9[7:0];
                        e_flag = sum9[8];
                        e_cls  = OC_FLAG;
                    end
                    ALU_SUB: begin
                        e_wx   = r_vx - r_vy;
                        e_flag = (r_vx >= r_vy);
                        e_cls  = OC_FLAG;
                    end
                    ALU_SHR: begin
                        e_wx   = {1'b0, r_vx[7:1]};
                        e_flag = r_vx[0];
                        e_cls  = OC_FLAG;
                    end
                    ALU_SUBN: begin
                        e_wx   = r_vy - r_vx;
                        e_flag = (r_vy >= r_vx);
                        e_cls  = OC_FLAG;
                    end
                    ALU_SHL: begin
                        e_wx   = {r_vx[6:0], 1'b0};
                        e_flag = r_vx[7];
                        e_cls  = OC_FLAG;
                    end
                    default: begin
                        e_wx_en = 1'b0;
                        e_pc    = r_pc;
                    end
                endcase
            end
            OP_LD_I: begin
                e_idx_en = 1'b1;
                e_idx    = {4'b0, op_nnn};
                e_pc     = pc2;
            end
            OP_JP_V0: e_pc = op_nnn + {4'b0, r_v0};
            OP_RND: begin
                e_wx_en = 1'b1;
                e_wx    = r_rnd & op_kk;
                e_pc    = pc2;
            end
            OP_DRW: begin
                e_cls  = (op_n == 4'd0) ? OC_DRAW0 : OC_DRAW;
                e_drew = 1'b1;
                e_pc   = pc2;
            end
            OP_SKP: begin
                if (op_kk == KEY_DOWN) begin
                    e_pc = key_down ? pc4 : pc2;
                end else if (op_kk == KEY_UP) begin
                    e_pc = key_down ? pc2 : pc4;
                end
            end
            default: begin
                e_pc = pc2;
                case (op_kk)
                    MISC_GET_DT: begin
                        e_wx_en = 1'b1;
                        e_wx    = r_dt;
                    end
                    MISC_WAIT: begin
                        e_wx_en = 1'b1;
                        e_wx    = {4'b0, r_waited};
                    end
                    MISC_SET_DT: e_dt_en = 1'b1;
                    MISC_SET_ST: e_st_en = 1'b1;
                    MISC_ADD_I: begin
                        e_idx_en = 1'b1;
                        e_idx    = sum17[15:0];
                        e_flag   = (sum17 > 17'h00FFF);
                        e_cls    = OC_FLAG;
                    end
                    MISC_FONT: begin
                        e_idx_en = 1'b1;
                        e_idx    = {6'b0, r_vx, 2'b0} + {8'b0, r_vx};
                    end
                    MISC_BCD:   e_cls = OC_BCD;
                    MISC_STORE: e_cls = OC_STORE;
                    MISC_LOAD:  e_cls = OC_LOAD;
                    default:    e_pc = r_pc;
                endcase
            end
        endcase
    end

    // ram address and write selection
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = '0;
        mem_wd   = r_hdata;
        reg_we   = 1'b0;
        reg_addr = '0;
        reg_wd   = 8'd0;
        frm_we   = 1'b0;
        frm_addr = '0;
        frm_wd   = 64'd0;
        case (i_ctl.step)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = i_ctl.cnt;
                mem_wd   = (i_ctl.cnt < CNT_W'(FONT_BYTES)) ? FONT[i_ctl.cnt[6:0]] : 8'd0;
                reg_we   = 1'b1;
                reg_addr = i_ctl.cnt[REG_AW-1:0];
                frm_we   = 1'b1;
                frm_addr = i_ctl.cnt[ROW_AW-1:0];
            end
            ST_HWR: begin
                mem_we   = 1'b1;
                mem_addr = r_haddr;
            end
            ST_HRD:  mem_addr = r_haddr;
            ST_HROW: frm_addr = r_haddr[ROW_AW-1:0];
            ST_F1:   mem_addr = r_pc;
            ST_F2:   mem_addr = r_pc + 12'd1;
            ST_F3:   reg_addr = op_x;
            ST_F4:   reg_addr = op_y;
            ST_F5:   reg_addr = '0;
            ST_EXEC: begin
                reg_we   = e_wx_en;
                reg_addr = op_x;
                reg_wd   = e_wx;
            end
            ST_WRF: begin
                reg_we   = 1'b1;
                reg_addr = FLAG_REG;
                reg_wd   = {7'b0, r_flag};
            end
            ST_CLS: begin
                frm_we   = 1'b1;
                frm_addr = i_ctl.cnt[ROW_AW-1:0];
            end
            ST_SPRA: begin
                mem_addr = r_idx[11:0] + {8'b0, i_ctl.cnt[3:0]};
                frm_addr = r_vy[ROW_AW-1:0] + i_ctl.cnt[ROW_AW-1:0];
            end
            ST_SPRB: begin
                frm_we   = 1'b1;
                frm_addr = r_vy[ROW_AW-1:0] + i_ctl.cnt[ROW_AW-1:0];
                frm_wd   = frm_rd ^ spr_mask;
            end
            ST_BCD: begin
                mem_we   = 1'b1;
                mem_addr = r_idx[11:0] + {10'b0, i_ctl.cnt[1:0]};
                mem_wd   = bcd_digit(r_vx, i_ctl.cnt[1:0]);
            end
            ST_STA: reg_addr = i_ctl.cnt[REG_AW-1:0];
            ST_STB: begin
                mem_we   = 1'b1;
                mem_addr = r_idx[11:0] + {8'b0, i_ctl.cnt[3:0]};
                mem_wd   = reg_rd;
            end
            ST_LDA: mem_addr = r_idx[11:0] + {8'b0, i_ctl.cnt[3:0]};
            ST_LDB: begin
                reg_we   = 1'b1;
                reg_addr = i_ctl.cnt[REG_AW-1:0];
                reg_wd   = mem_rd;
            end
            default: mem_addr = '0;
        endcase
    end

    // main memory, register file and screen
    c8cpu_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    c8cpu_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_addr  (reg_addr),
        .i_wdata (reg_wd),
        .o_rdata (reg_rd)
    );

    c8cpu_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_frame (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_addr  (frm_addr),
        .i_wdata (frm_wd),
        .o_rdata (frm_rd)
    );

    // pc, index, stack, timers and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_idx       <= '0;
            r_sp        <= '0;
            r_dt        <= '0;
            r_st        <= '0;
            r_stack     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.step == ST_EXEC) begin
                r_pc <= e_pc;
                if (e_push) begin
                    r_stack[r_sp] <= r_pc;
                    r_sp          <= sp_inc;
                end
                if (e_pop) begin
                    r_sp <= sp_dec;
                end
                if (e_idx_en) begin
                    r_idx <= e_idx;
                end
                if (e_dt_en) begin
                    r_dt <= r_vx;
                end
                if (e_st_en) begin
                    r_st <= r_vx;
                end
            end
            if (((i_ctl.step == ST_STB) || (i_ctl.step == ST_LDB)) && loop_last) begin
                r_idx <= r_idx + {12'b0, op_x} + 16'd1;
            end
            if (i_ctl.step == ST_FIN) begin
                if (r_dt != 8'd0) begin
                    r_dt <= r_dt - 8'd1;
                end
                if (r_st != 8'd0) begin
                    r_st <= r_st - 8'd1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_hcmd   <= t_host_cmd'(i_cmd);
            r_haddr  <= i_address;
            r_hdata  <= i_data_byte;
            r_keys   <= i_keys_down;
            r_waited <= i_waited_key;
            r_rnd    <= i_random_byte;
            r_drew   <= 1'b0;
            r_beep   <= 1'b0;
            r_rd     <= 8'd0;
            r_row    <= 64'd0;
        end
        case (i_ctl.step)
            ST_F2: r_ophi <= mem_rd;
            ST_F3: r_oplo <= mem_rd;
            ST_F4: r_vx   <= reg_rd;
            ST_F5: r_vy   <= reg_rd;
            ST_F6: r_v0   <= reg_rd;
            ST_EXEC: begin
                r_drew <= e_drew;
                r_flag <= e_flag;
            end
            ST_SPRB: r_flag <= r_flag | (|(frm_rd & spr_mask));
            ST_HCAP: begin
                if (r_hcmd == HC_READ) begin
                    r_rd <= mem_rd;
                end else begin
                    r_row <= frm_rd;
                end
            end
            ST_FIN: r_beep <= (r_st == 8'd1);
            default: r_flag <= r_flag;
        endcase
        if (load_out) begin
            r_opc   <= r_pc;
            r_ord   <= r_rd;
            r_orow  <= r_row;
            r_odrew <= r_drew;
            r_obeep <= r_beep;
        end
    end

    assign o_stat.hcmd     = r_hcmd;
    assign o_stat.cls      = e_cls;
    assign o_stat.lim      = (op_nib == OP_DRW) ? op_n : op_x;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_program_counter = r_opc;
    assign o_read_byte       = r_ord;
    assign o_screen_row      = r_orow;
    assign o_drew            = r_odrew;
    assign o_beep            = r_obeep;
endmodule

// ===== hw/rtl/chip8_cpu_core.sv =====
// Path from accept to response valid: a memory write, a memory or row read, or an execute;
// an execute adds a VF write, a clear, a sprite loop per row, BCD or an FX55/FX65 loop.
// Throughput: one transaction in flight; the next request is accepted in the cycle after
// the result is loaded, while that result may still wait in the output register.
// Reset: synchronous active low, then a sweep loads the font and clears memory,
// registers and screen; no request is accepted during it.
// ----------------------------------------------------------------------------
// chip8_cpu_core
// CHIP-8 machine: sequencer plus datapath behind request/response channels.
// ----------------------------------------------------------------------------
module chip8_cpu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c8cpu_req_if.sink   i_req,
    c8cpu_rsp_if.source o_rsp
);
    import c8cpu_pkg::*;

    t_ctl  ctl;
    t_stat stat;
    logic  in_ready;

    // sequencer
    c8cpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // datapath
    c8cpu_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_cmd             (i_req.cmd),
        .i_address         (i_req.address),
        .i_data_byte       (i_req.data_byte),
        .i_keys_down       (i_req.keys_down),
        .i_waited_key      (i_req.waited_key),
        .i_random_byte     (i_req.random_byte),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_program_counter (o_rsp.program_counter),
        .o_read_byte       (o_rsp.read_byte),
        .o_screen_row      (o_rsp.screen_row),
        .o_drew            (o_rsp.drew),
        .o_beep            (o_rsp.beep)
    );

    assign i_req.ready = in_ready;

`ifndef ASSERT_OFF
    // an accepted request is dispatched on the next cycle
    a_take_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (ctl.step == ST_DISP))
        else $error("accepted request not dispatched");

    // a new result appears only out of the handoff step
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(ctl.step == ST_DONE))
        else $error("result raised outside handoff");

    // no result is presented and no request is accepted while the reset sweep runs
    a_sweep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.step == ST_CLEAR) |-> (!o_rsp.valid && !i_req.ready))
        else $error("activity during reset sweep");

    // handoff never leaves while the output register is still full
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ctl.step == ST_DONE) && o_rsp.valid && !o_rsp.ready) |=> (ctl.step == ST_DONE))
        else $error("result overwritten");
`endif
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the CHIP-8 core: small programs are loaded byte by byte at the
// current PC and executed, with memory and screen reads between them. A
// scoreboard runs its own model of the machine and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
    import c8cpu_pkg::*;

    // opcode groups (top nibble)
    localparam logic [3:0] G_SYS = 4'h0, G_JP = 4'h1, G_CALL = 4'h2, G_SE = 4'h3;
    localparam logic [3:0] G_SNE = 4'h4, G_SER = 4'h5, G_LD = 4'h6, G_ADD = 4'h7;
    localparam logic [3:0] G_ALU = 4'h8, G_SNER = 4'h9, G_LDI = 4'hA, G_JPV = 4'hB;
    localparam logic [3:0] G_RND = 4'hC, G_DRW = 4'hD, G_KEY = 4'hE, G_MISC = 4'hF;
    // low byte sub-codes
    localparam logic [7:0] K_CLS = 8'hE0, K_RET = 8'hEE, K_SKP = 8'h9E, K_SKNP = 8'hA1;
    localparam logic [7:0] K_GDT = 8'h07, K_WKEY = 8'h0A, K_SDT = 8'h15, K_SST = 8'h18;
    localparam logic [7:0] K_ADDI = 8'h1E, K_FONT = 8'h29, K_BCD = 8'h33;
    localparam logic [7:0] K_STORE = 8'h55, K_LOAD = 8'h65;
    // alu sub-codes
    localparam logic [3:0] A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3;
    localparam logic [3:0] A_ADD = 4'h4, A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7;
    localparam logic [3:0] A_SHL = 4'hE;

    typedef struct {
        t_host_cmd   cmd;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [15:0] keys_down;
        logic [3:0]  waited_key;
        logic [7:0]  random_byte;
    } t_req;

    typedef struct {
        logic [11:0] program_counter;
        logic [7:0]  read_byte;
        logic [63:0] screen_row;
        logic        drew;
        logic        beep;
    } t_rsp;

    // machine model and response queue
    class cpu_scoreboard;
        logic [7:0]  v[16];
        logic [11:0] pc;
        logic [15:0] idx;
        logic [11:0] stk[STACK_DEPTH];
        logic [3:0]  sp;
        logic [7:0]  dt, st;
        logic [7:0]  mem[MEMORY_BYTES];
        logic [63:0] scr[SCREEN_HEIGHT];
        t_rsp        pend[$];
        int          errors;

        function new();
            foreach (v[i]) v[i] = '0;
            foreach (stk[i]) stk[i] = '0;
            foreach (mem[i]) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
            foreach (scr[i]) scr[i] = '0;
            pc = PC_RESET; idx = '0; sp = '0; dt = '0; st = '0; errors = 0;
        endfunction

        function logic draw(logic [7:0] x0, logic [7:0] y0, int rows);
            logic        hit;
            logic [7:0]  bits;
            logic [4:0]  y;
            logic [5:0]  x;
            logic [63:0] mask;
            hit = 1'b0;
            for (int r = 0; r < rows; r++) begin
                bits = mem[12'(idx + r)];
                y = 5'(y0 + r);
                mask = '0;
                for (int c = 0; c < 8; c++) begin
                    if (bits[7-c]) begin
                        x = 6'(x0 + c);
                        mask[63-x] = 1'b1;
                    end
                end
                if ((scr[y] & mask) != 0) hit = 1'b1;
                scr[y] ^= mask;
            end
            return hit;
        endfunction

        function logic run_op(logic [15:0] keys, logic [3:0] wk, logic [7:0] rnd);
            logic [15:0] op;
            logic [3:0]  x, y;
            logic [11:0] nnn, nxt, skp, npc;
            logic [7:0]  kk, vx, vy;
            logic [16:0] sum;
            logic        drew, down;
            op = {mem[pc], mem[12'(pc + 1)]};
            x = op[11:8]; y = op[7:4]; nnn = op[11:0]; kk = op[7:0];
            vx = v[x]; vy = v[y];
            nxt = pc + 12'd2; skp = pc + 12'd4; npc = pc;
            drew = 1'b0;
            case (op[15:12])
                G_SYS: begin
                    if (kk == K_CLS) begin
                        foreach (scr[i]) scr[i] = '0;
                        drew = 1'b1; npc = nxt;
                    end else if (kk == K_RET) begin
                        sp = sp - 4'd1;
                        npc = stk[sp] + 12'd2;
                    end
                end
                G_JP: npc = nnn;
                G_CALL: begin
                    stk[sp] = pc; sp = sp + 4'd1; npc = nnn;
                end
                G_SE:   npc = (vx == kk) ? skp : nxt;
                G_SNE:  npc = (vx != kk) ? skp : nxt;
                G_SER:  npc = (vx == vy) ? skp : nxt;
                G_LD:   begin v[x] = kk; npc = nxt; end
                G_ADD:  begin v[x] = vx + kk; npc = nxt; end
                G_ALU: begin
                    npc = nxt;
                    case (op[3:0])
                        A_MOV: v[x] = vy;
                        A_OR:  v[x] = vx | vy;
                        A_AND: v[x] = vx & vy;
                        A_XOR: v[x] = vx ^ vy;
                        A_ADD: begin v[x] = vx + vy; v[15] = ({1'b0, vx} + vy > 9'hFF); end
                        A_SUB: begin v[x] = vx - vy; v[15] = (vx < vy) ? 8'd0 : 8'd1; end
                        A_SHR: begin v[x] = vx >> 1; v[15] = {7'd0, vx[0]}; end
                        A_SUBN: begin v[x] = vy - vx; v[15] = (vy < vx) ? 8'd0 : 8'd1; end
                        A_SHL: begin v[x] = vx << 1; v[15] = {7'd0, vx[7]}; end
                        default: npc = pc;
                    endcase
                end
                G_SNER: npc = (vx != vy) ? skp : nxt;
                G_LDI:  begin idx = {4'd0, nnn}; npc = nxt; end
                G_JPV:  npc = nnn + v[0];
                G_RND:  begin v[x] = rnd & kk; npc = nxt; end
                G_DRW: begin
                    v[15] = {7'd0, draw(vx, vy, op[3:0])};
                    drew = 1'b1; npc = nxt;
                end
                G_KEY: begin
                    down = keys[vx[3:0]];
                    if (kk == K_SKP) npc = down ? skp : nxt;
                    else if (kk == K_SKNP) npc = down ? nxt : skp;
                end
                default: begin
                    npc = nxt;
                    case (kk)
                        K_GDT:  v[x] = dt;
                        K_WKEY: v[x] = {4'd0, wk};
                        K_SDT:  dt = vx;
                        K_SST:  st = vx;
                        K_ADDI: begin
                            sum = idx + vx;
                            idx = sum[15:0];
                            v[15] = (sum > 17'hFFF) ? 8'd1 : 8'd0;
                        end
                        K_FONT: idx = vx * 16'd5;
                        K_BCD: begin
                            mem[12'(idx)]     = vx / 100;
                            mem[12'(idx + 1)] = (vx / 10) % 10;
                            mem[12'(idx + 2)] = vx % 10;
                        end
                        K_STORE: begin
                            for (int i = 0; i <= x; i++) mem[12'(idx + i)] = v[i];
                            idx = idx + x + 16'd1;
                        end
                        K_LOAD: begin
                            for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + i)];
                            idx = idx + x + 16'd1;
                        end
                        default: npc = pc;
                    endcase
                end
            endcase
            pc = npc;
            return drew;
        endfunction

        // accepted request: work out the response
        function void note(t_req r);
            t_rsp e;
            e.read_byte = '0; e.screen_row = '0; e.drew = 1'b0; e.beep = 1'b0;
            case (r.cmd)
                HC_EXEC: begin
                    e.drew = run_op(r.keys_down, r.waited_key, r.random_byte);
                    if (dt != 0) dt--;
                    if (st != 0) begin
                        e.beep = (st == 8'd1);
                        st--;
                    end
                end
                HC_WRITE: mem[r.address] = r.data_byte;
                HC_READ:  e.read_byte = mem[r.address];
                default:  e.screen_row = scr[r.address[4:0]];
            endcase
            e.program_counter = pc;
            pend.push_back(e);
        endfunction

        function void report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endfunction

        function void check(t_rsp g);
            t_rsp e;
            if (pend.size() == 0) begin
                report("response with no request outstanding");
                return;
            end
            e = pend.pop_front();
            if (g.program_counter !== e.program_counter)
                report($sformatf("pc %h, want %h", g.program_counter, e.program_counter));
            if (g.read_byte !== e.read_byte)
                report($sformatf("read_byte %h, want %h", g.read_byte, e.read_byte));
            if (g.screen_row !== e.screen_row)
                report($sformatf("screen_row %h, want %h", g.screen_row, e.screen_row));
            if (g.drew !== e.drew)
                report($sformatf("drew %b, want %b", g.drew, e.drew));
            if (g.beep !== e.beep)
                report($sformatf("beep %b, want %b", g.beep, e.beep));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    c8cpu_req_if req();
    c8cpu_rsp_if rsp();

    chip8_cpu_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    cpu_scoreboard sb = new();
    bit quiet;
    bit hold_req;
    int sent;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    // response sampling
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check('{rsp.program_counter, rsp.read_byte, rsp.screen_row,
                       rsp.drew, rsp.beep});
    end

    // receiver side: random ready bursts, long hold-offs on request
    initial begin
        rsp.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                rsp.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                rsp.ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // one transaction on the request channel, then maybe a gap
    task automatic send(t_req r);
        req.valid       <= 1'b1;
        req.cmd         <= r.cmd;
        req.address     <= r.address;
        req.data_byte   <= r.data_byte;
        req.keys_down   <= r.keys_down;
        req.waited_key  <= r.waited_key;
        req.random_byte <= r.random_byte;
        do @(posedge i_clk); while (!req.ready);
        sb.note(r);
        sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic host(t_host_cmd c, logic [11:0] a, logic [7:0] d);
        t_req r;
        r.cmd = c; r.address = a; r.data_byte = d;
        r.keys_down = 16'($urandom); r.waited_key = 4'($urandom);
        r.random_byte = 8'($urandom);
        send(r);
    endtask

    // place an opcode at the current pc and execute it
    task automatic exec_op(logic [15:0] op, logic [15:0] keys, logic [3:0] wk,
                           logic [7:0] rnd);
        t_req r;
        host(HC_WRITE, sb.pc, op[15:8]);
        host(HC_WRITE, 12'(sb.pc + 1), op[7:0]);
        r.cmd = HC_EXEC; r.address = 12'($urandom); r.data_byte = 8'($urandom);
        r.keys_down = keys; r.waited_key = wk; r.random_byte = rnd;
        send(r);
    endtask

    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        logic [7:0]  misc[9];
        misc = '{K_GDT, K_WKEY, K_SDT, K_SST, K_ADDI, K_FONT, K_BCD, K_STORE, K_LOAD};
        op = 16'($urandom);
        case (op[15:12])
            G_SYS: case ($urandom_range(0, 2))
                0: op[7:0] = K_CLS;
                1: op[7:0] = K_RET;
                default: ;
            endcase
            G_ALU: if ($urandom_range(0, 7) != 0) begin
                op[3:0] = 4'($urandom_range(0, 8));
                if (op[3:0] == 4'd8) op[3:0] = A_SHL;
            end
            G_DRW: if ($urandom_range(0, 1)) op[3:0] = 4'($urandom_range(0, 3));
            G_KEY: case ($urandom_range(0, 4))
                0, 1: op[7:0] = K_SKP;
                2, 3: op[7:0] = K_SKNP;
                default: ;
            endcase
            G_MISC: if ($urandom_range(0, 7) != 0) op[7:0] = misc[$urandom_range(0, 8)];
            default: ;
        endcase
        return op;
    endfunction

    // main stimulus
    initial begin
        quiet = 1'b0; hold_req = 1'b0; sent = 0;
        i_rst_n         <= 1'b0;
        req.valid       <= 1'b0;
        req.cmd         <= HC_EXEC;
        req.address     <= '0;
        req.data_byte   <= '0;
        req.keys_down   <= '0;
        req.waited_key  <= '0;
        req.random_byte <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: host access at the extremes
        host(HC_READ, 12'h000, 8'h00);
        host(HC_WRITE, 12'hFFF, 8'hFF);
        host(HC_READ, 12'hFFF, 8'h00);
        host(HC_ROW, 12'hFFF, 8'h00);
        // directed: clear, register wrap, flags into VF, wrapping sprites
        exec_op({G_SYS, 4'hF, K_CLS}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_LD, 4'hA, 8'hFF}, 16'hFFFF, 4'hF, 8'hFF);
        exec_op({G_ADD, 4'hA, 8'h01}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_LD, 4'hF, 8'hFF}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_ALU, 4'hF, 4'hF, A_ADD}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_LDI, 12'hFFE}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_LD, 4'h1, 8'h3E}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_LD, 4'h2, 8'h1F}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_DRW, 4'h1, 4'h2, 4'hF}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_DRW, 4'h1, 4'h2, 4'hF}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_DRW, 4'h1, 4'h2, 4'h0}, 16'h0000, 4'h0, 8'h00);
        host(HC_ROW, 12'h01F, 8'h00);
        exec_op({G_MISC, 4'h3, K_WKEY}, 16'h0000, 4'hF, 8'h00);
        exec_op({G_KEY, 4'h3, K_SKP}, 16'hFFFF, 4'h0, 8'h00);
        exec_op({G_ALU, 4'h3, 4'h3, 4'h9}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_MISC, 4'h0, 8'h99}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_MISC, 4'hF, K_STORE}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_CALL, 12'hFFE}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_SYS, 4'h0, K_RET}, 16'h0000, 4'h0, 8'h00);
        exec_op({G_JPV, 12'hFFF}, 16'h0000, 4'h0, 8'h00);

        // random programs with host reads and stray writes mixed in
        while (sent < 1400) begin
            if (sent > 300 && sent < 310 && !hold_req) hold_req = 1'b1;
            if (sent >= 700 && sent < 704) begin
                req.valid <= 1'b0;
                do @(posedge i_clk); while (sb.pend.size() != 0);
            end
            if (sent > 1200) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0: host(HC_READ, 12'($urandom), 8'h00);
                1: host(HC_ROW, 12'($urandom), 8'h00);
                2: if ($urandom_range(0, 3) == 0) host(HC_WRITE, 12'($urandom), 8'($urandom));
                   else exec_op(rand_op(), 16'($urandom), 4'($urandom), 8'($urandom));
                default: exec_op(rand_op(), 16'($urandom), 4'($urandom), 8'($urandom));
            endcase
        end
        req.valid <= 1'b0;

        // drain
        while (sb.pend.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
